FILE: design/rge_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rge_pkg: shared types and constants
// Register indexes, reset values and the item record that travels from the
// front end through the queue to the residual back end.
// ----------------------------------------------------------------------------
package rge_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_ENABLE = 1'b1;

  localparam logic [CFG_DATA_W-1:0] ROW_WIDTH_RESET = 13'd1920;

  // left predictor start value for green and alpha in a first row
  localparam logic [7:0] LEFT_INIT_GA = 8'h80;

  // front-to-back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  // one classified pixel with its line-store word (A,R,B,G from msb)
  typedef struct packed {
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [31:0] above;
    logic        first_row;
    logic        row_start;
    logic        row_end;
  } rge_entry_t;

endpackage

FILE: design/rge_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rge channel interfaces
// Pixel request channel, residual channel and configuration write channel.
// ----------------------------------------------------------------------------
interface rge_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] red_in;
  logic [7:0] alpha_in;
  logic       frame_start;

  modport source (output valid, green_in, blue_in, red_in, alpha_in, frame_start,
                  input ready);
  modport sink   (input valid, green_in, blue_in, red_in, alpha_in, frame_start,
                  output ready);
endinterface

interface rge_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] green_residual;
  logic [7:0] blue_residual;
  logic [7:0] red_residual;
  logic [7:0] alpha_residual;
  logic       row_end;

  modport source (output valid, green_residual, blue_residual, red_residual,
                  alpha_residual, row_end, input ready);
  modport sink   (input valid, green_residual, blue_residual, red_residual,
                  alpha_residual, row_end, output ready);
endinterface

interface rge_cfg_if import rge_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/rge_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rge_front: pixel intake and row tracking
// Tracks column and first-row state, classifies each pixel, reads the pixel
// above from the line store and writes the current pixel in its place.
// ----------------------------------------------------------------------------
module rge_front import rge_pkg::*; #(
  parameter int  MAX_ROW_PIXELS = 4096,
  localparam int CW = $clog2(MAX_ROW_PIXELS),
  localparam int WW = CW + 1
) (
  input  logic          clk,
  input  logic          rst,
  rge_pix_if.sink       pix,
  input  logic [WW-1:0] width_eff,
  output logic          stg_valid,
  output rge_entry_t    stg,
  input  logic          q_ready
);

  logic [CW-1:0] col;
  logic          first_row;

  logic          acc;
  logic [CW-1:0] cur_col;
  logic [WW-1:0] col_inc;
  logic          cur_first;
  logic          cur_start;
  logic          cur_last;

  // line store, one word per column
  logic [31:0] line_mem [MAX_ROW_PIXELS];

  assign pix.ready = !stg_valid || q_ready;
  assign acc       = pix.valid && pix.ready;

  // classify: frame start forces column 0 of a first row
  always_comb begin
    cur_col   = pix.frame_start ? '0 : col;
    cur_first = pix.frame_start || first_row;
    cur_start = pix.frame_start || (col == '0);
    col_inc   = {1'b0, cur_col} + WW'(1);
    cur_last  = (col_inc >= width_eff);
  end

  // row tracking and stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      first_row <= 1'b1;
      stg_valid <= 1'b0;
    end else begin
      if (acc) begin
        col       <= cur_last ? '0 : col_inc[CW-1:0];
        first_row <= cur_last ? 1'b0 : cur_first;
      end
      if (acc) begin
        stg_valid <= 1'b1;
      end else if (q_ready) begin
        stg_valid <= 1'b0;
      end
    end
  end

  // stage payload; store read returns the previous row's word
  always_ff @(posedge clk) begin
    if (acc) begin
      stg.green     <= pix.green_in;
      stg.blue      <= pix.blue_in;
      stg.red       <= pix.red_in;
      stg.alpha     <= pix.alpha_in;
      stg.first_row <= cur_first;
      stg.row_start <= cur_start;
      stg.row_end   <= cur_last;
      stg.above     <= line_mem[cur_col];
      line_mem[cur_col] <= {pix.alpha_in, pix.red_in, pix.blue_in, pix.green_in};
    end
  end

endmodule

FILE: design/rge_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rge_queue: short decoupling queue
// Small FIFO between the front end and the residual back end.
// ----------------------------------------------------------------------------
module rge_queue import rge_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  rge_entry_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output rge_entry_t pop_data
);

  rge_entry_t          entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: design/rge_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rge_back: residual computation
// Forms decorrelated gradient values, differences them against the left
// predictors and holds the result in the output register.
// ----------------------------------------------------------------------------
module rge_back import rge_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  output logic       q_ready,
  input  rge_entry_t q_data,
  input  logic       alpha_enable,
  rge_res_if.source  res
);

  logic [7:0] left_green;
  logic [7:0] left_blue;
  logic [7:0] left_red;
  logic [7:0] left_alpha;

  logic       take;
  logic [7:0] gv, bv, rv, av;
  logic [7:0] lg, lb, lr, la;

  assign q_ready = !res.valid || res.ready;
  assign take    = q_valid && q_ready;

  // gradient values and left predictor selection
  always_comb begin
    if (q_data.first_row) begin
      gv = q_data.green;
      bv = q_data.blue - q_data.green;
      rv = q_data.red - q_data.green;
      av = q_data.alpha;
    end else begin
      gv = q_data.green - q_data.above[7:0];
      bv = (q_data.blue - q_data.above[15:8]) - gv;
      rv = (q_data.red - q_data.above[23:16]) - gv;
      av = q_data.alpha - q_data.above[31:24];
    end
    if (q_data.row_start) begin
      lg = q_data.first_row ? LEFT_INIT_GA : 8'h00;
      lb = 8'h00;
      lr = 8'h00;
      la = q_data.first_row ? LEFT_INIT_GA : 8'h00;
    end else begin
      lg = left_green;
      lb = left_blue;
      lr = left_red;
      la = left_alpha;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (take) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  // result payload and left predictors
  always_ff @(posedge clk) begin
    if (take) begin
      res.green_residual <= gv - lg;
      res.blue_residual  <= bv - lb;
      res.red_residual   <= rv - lr;
      res.alpha_residual <= alpha_enable ? (av - la) : 8'h00;
      res.row_end        <= q_data.row_end;
      left_green         <= gv;
      left_blue          <= bv;
      left_red           <= rv;
      left_alpha         <= av;
    end
  end

endmodule

FILE: design/rgba_gradient_residual_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_gradient_residual_encoder_top: RGBA gradient residual encoder
// Usage:
//   pix : one pixel (G,B,R,A, frame_start) per request, valid/ready.
//   res : one residual set (G,B-G,R-G,A, row_end) per pixel, valid/ready.
//   cfg : register writes (0 = row_width, 1 = alpha_enable), always ready;
//         write only while no pixel is in flight.
// Throughput is one pixel per cycle while res does not stall: the front end
// does a single line-store read and write per pixel, the back end only byte
// subtractions. A result passes the front stage register, the queue and the
// output register before it is valid.
// When res stalls, the output register holds, the 2-entry queue and the
// front stage fill, and pix.ready drops; up to 4 pixels are in flight.
// Reset clears the row tracking to column 0 of a first row and empties the
// pipeline; no clearing pass is needed, as the line store word is only used in
// rows after the first, at columns already written.
// ----------------------------------------------------------------------------
module rgba_gradient_residual_encoder_top import rge_pkg::*; #(
  parameter int MAX_ROW_PIXELS = 4096
) (
  input  logic      clk,
  input  logic      rst,
  rge_pix_if.sink   pix,
  rge_res_if.source res,
  rge_cfg_if.sink   cfg
);

  localparam int CW   = $clog2(MAX_ROW_PIXELS);
  localparam int WW   = CW + 1;
  localparam int CMPW = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;

  logic [CFG_DATA_W-1:0] row_width;
  logic                  alpha_enable;
  logic [CMPW-1:0]       width_ext;
  logic [WW-1:0]         width_eff;

  logic       stg_valid;
  rge_entry_t stg_entry;
  logic       q_push_ready;
  logic       q_pop_valid;
  logic       q_pop_ready;
  rge_entry_t q_pop_data;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width    <= ROW_WIDTH_RESET;
      alpha_enable <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ROW_WIDTH:    row_width    <= cfg.data;
        REG_ALPHA_ENABLE: alpha_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // effective row width: zero acts as one, saturate at the store depth
  always_comb begin
    width_ext = CMPW'(row_width);
    if (width_ext == '0) begin
      width_eff = WW'(1);
    end else if (width_ext > CMPW'(MAX_ROW_PIXELS)) begin
      width_eff = WW'(MAX_ROW_PIXELS);
    end else begin
      width_eff = width_ext[WW-1:0];
    end
  end

  rge_front #(
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix),
    .width_eff (width_eff),
    .stg_valid (stg_valid),
    .stg       (stg_entry),
    .q_ready   (q_push_ready)
  );

  rge_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (stg_valid),
    .push_ready (q_push_ready),
    .push_data  (stg_entry),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  rge_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_pop_valid),
    .q_ready      (q_pop_ready),
    .q_data       (q_pop_data),
    .alpha_enable (alpha_enable),
    .res          (res)
  );

  // frame start always opens a first row at column 0
  a_frame_start_class: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready && pix.frame_start) |=>
      (stg_valid && stg_entry.first_row && stg_entry.row_start))
    else $error("frame start not classified as first-row start");

  // a one-pixel row ends at every pixel
  a_single_pixel_row: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready && (width_eff == WW'(1))) |=> stg_entry.row_end)
    else $error("row end missing for one-pixel rows");

  // front stage holds while the queue is full
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (stg_valid && !q_push_ready) |=> (stg_valid && $stable(stg_entry)))
    else $error("front stage lost or changed while queue full");

endmodule
